// ===== src/iweg_pkg.sv =====
// shared types, constants and reciprocal table of the isometric edge generator
`timescale 1ns / 1ps
package iweg_pkg;

    // register indexes on the configuration port
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_CAM_X       = 3'd0;
    localparam reg_idx_t REG_CAM_Y       = 3'd1;
    localparam reg_idx_t REG_ZOOM        = 3'd2;
    localparam reg_idx_t REG_DEPTH_RATIO = 3'd3;
    localparam reg_idx_t REG_ALTITUDE    = 3'd4;
    localparam reg_idx_t REG_DRAW_MODE   = 3'd5;

    // drawing modes
    localparam logic [1:0] MODE_GRID      = 2'd0;
    localparam logic [1:0] MODE_DIAG      = 2'd1;
    localparam logic [1:0] MODE_TRI_BOTH  = 2'd2;
    localparam logic [1:0] MODE_TRI_UPPER = 2'd3;

    // primitive kinds
    localparam logic KIND_SEG = 1'b0;
    localparam logic KIND_TRI = 1'b1;

    // emission slots: neighbor used as second vertex
    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_LEFT = 2'd0;
    localparam slot_t SLOT_UP   = 2'd1;
    localparam slot_t SLOT_DIAG = 2'd2;

    // reciprocal of the depth ratio, scaled by 2^RECIP_SHIFT and rounded up
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 28;
    localparam int RECIP_ONE   = 134217728;

    // configuration registers (signed ones are stored as raw bits)
    typedef struct packed {
        logic [15:0] cam_x;
        logic [15:0] cam_y;
        logic [10:0] zoom;
        logic [4:0]  depth_ratio;
        logic [6:0]  altitude;
        logic [1:0]  draw_mode;
    } cfg_t;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    typedef struct packed {
        logic   last;
        logic   kind;
        point_t c;
        point_t b;
        point_t a;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  load_point;
        logic  load_out;
        slot_t slot;
        logic  last;
        logic  commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_grid;
        logic col_nz;
        logic row_nz;
    } dp_status_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [4:0] r);
        logic [RECIP_W-1:0] m;
        case (r)
            5'd2:    m = RECIP_W'((RECIP_ONE + 1) / 2);
            5'd3:    m = RECIP_W'((RECIP_ONE + 2) / 3);
            5'd4:    m = RECIP_W'((RECIP_ONE + 3) / 4);
            5'd5:    m = RECIP_W'((RECIP_ONE + 4) / 5);
            5'd6:    m = RECIP_W'((RECIP_ONE + 5) / 6);
            5'd7:    m = RECIP_W'((RECIP_ONE + 6) / 7);
            5'd8:    m = RECIP_W'((RECIP_ONE + 7) / 8);
            5'd9:    m = RECIP_W'((RECIP_ONE + 8) / 9);
            5'd10:   m = RECIP_W'((RECIP_ONE + 9) / 10);
            5'd11:   m = RECIP_W'((RECIP_ONE + 10) / 11);
            5'd12:   m = RECIP_W'((RECIP_ONE + 11) / 12);
            5'd13:   m = RECIP_W'((RECIP_ONE + 12) / 13);
            5'd14:   m = RECIP_W'((RECIP_ONE + 13) / 14);
            5'd15:   m = RECIP_W'((RECIP_ONE + 14) / 15);
            5'd16:   m = RECIP_W'((RECIP_ONE + 15) / 16);
            5'd17:   m = RECIP_W'((RECIP_ONE + 16) / 17);
            5'd18:   m = RECIP_W'((RECIP_ONE + 17) / 18);
            5'd19:   m = RECIP_W'((RECIP_ONE + 18) / 19);
            5'd20:   m = RECIP_W'((RECIP_ONE + 19) / 20);
            5'd21:   m = RECIP_W'((RECIP_ONE + 20) / 21);
            5'd22:   m = RECIP_W'((RECIP_ONE + 21) / 22);
            5'd23:   m = RECIP_W'((RECIP_ONE + 22) / 23);
            5'd24:   m = RECIP_W'((RECIP_ONE + 23) / 24);
            5'd25:   m = RECIP_W'((RECIP_ONE + 24) / 25);
            5'd26:   m = RECIP_W'((RECIP_ONE + 25) / 26);
            5'd27:   m = RECIP_W'((RECIP_ONE + 26) / 27);
            5'd28:   m = RECIP_W'((RECIP_ONE + 27) / 28);
            5'd29:   m = RECIP_W'((RECIP_ONE + 28) / 29);
            5'd30:   m = RECIP_W'((RECIP_ONE + 29) / 30);
            5'd31:   m = RECIP_W'((RECIP_ONE + 30) / 31);
            // ratio of one, and zero treated as one
            default: m = RECIP_W'(RECIP_ONE);
        endcase
        return m;
    endfunction

endpackage

// ===== src/iweg_regs.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module iweg_regs
    import iweg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cam_x       <= '0;
            cfg_reg.cam_y       <= '0;
            cfg_reg.zoom        <= 11'd1;
            cfg_reg.depth_ratio <= 5'd2;
            cfg_reg.altitude    <= '0;
            cfg_reg.draw_mode   <= MODE_GRID;
        end else if (wr_en) begin
            unique case (idx)
                REG_CAM_X:       cfg_reg.cam_x       <= pwdata[15:0];
                REG_CAM_Y:       cfg_reg.cam_y       <= pwdata[15:0];
                REG_ZOOM:        cfg_reg.zoom        <= pwdata[10:0];
                REG_DEPTH_RATIO: cfg_reg.depth_ratio <= pwdata[4:0];
                REG_ALTITUDE:    cfg_reg.altitude    <= pwdata[6:0];
                REG_DRAW_MODE:   cfg_reg.draw_mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_CAM_X:       prdata = 32'(cfg_reg.cam_x);
            REG_CAM_Y:       prdata = 32'(cfg_reg.cam_y);
            REG_ZOOM:        prdata = 32'(cfg_reg.zoom);
            REG_DEPTH_RATIO: prdata = 32'(cfg_reg.depth_ratio);
            REG_ALTITUDE:    prdata = 32'(cfg_reg.altitude);
            REG_DRAW_MODE:   prdata = 32'(cfg_reg.draw_mode);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== src/iweg_datapath.sv =====
// projection arithmetic, row store, neighbor registers and output word register
`timescale 1ns / 1ps
module iweg_datapath
    import iweg_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic [9:0]  s_col,
    input  logic [9:0]  s_row,
    input  logic [15:0] s_height,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output out_word_t   out_word
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // captured input word
    logic [9:0]  col_reg;
    logic [9:0]  row_reg;
    logic [15:0] height_reg;

    // pipeline registers, free running while the input word holds
    logic signed [22:0] dx_reg;
    logic [21:0]        ds_reg;
    logic signed [23:0] hm_reg;
    logic [35:0]        p_lo_reg;
    logic [35:0]        p_hi_reg;
    logic signed [35:0] hz_reg;
    logic [21:0]        q_reg;
    logic signed [33:0] t_reg;

    // points
    point_t p_reg;
    point_t p_next;
    point_t up_reg;
    point_t left_reg;
    point_t ul_reg;
    out_word_t out_reg;

    point_t row_mem [MAX_COLS];

    logic [CW-1:0] addr;

    // stage one operands
    logic signed [22:0] diff_w;
    logic signed [22:0] zoom23;
    logic [21:0]        sum_w;
    logic signed [23:0] h_w;
    logic signed [23:0] alt1_w;

    // stage two operands
    logic [RECIP_W-1:0] recip;
    logic signed [35:0] hm_w;
    logic signed [35:0] zoom36;

    // stage three and four
    logic [49:0]        prod;
    logic signed [35:0] hz_adj;
    logic signed [37:0] ys_sum;
    logic signed [23:0] xs_sum;

    // output word forming
    logic   is_tri;
    point_t b_sel;

    assign addr = CW'(col_reg);

    assign status.in_grid = (32'(col_reg) < MAX_COLS) && (32'(row_reg) < MAX_ROWS);
    assign status.col_nz  = |col_reg;
    assign status.row_nz  = |row_reg;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            col_reg    <= s_col;
            row_reg    <= s_row;
            height_reg <= s_height;
        end
    end

    // stage one: grid products, height scale, row store read
    assign diff_w = $signed(23'(col_reg)) - $signed(23'(row_reg));
    assign zoom23 = $signed(23'(cfg.zoom));
    assign sum_w  = 22'(col_reg) + 22'(row_reg);
    assign h_w    = 24'($signed(height_reg));
    assign alt1_w = 24'($signed(cfg.altitude)) + 24'sd1;

    always_ff @(posedge aclk) begin
        dx_reg <= diff_w * zoom23;
        ds_reg <= sum_w * 22'(cfg.zoom);
        hm_reg <= h_w * alt1_w;
        up_reg <= row_mem[addr];
    end

    // stage two: reciprocal partial products, height times zoom
    assign recip  = recip_of(cfg.depth_ratio);
    assign hm_w   = 36'(hm_reg);
    assign zoom36 = $signed(36'(cfg.zoom));

    always_ff @(posedge aclk) begin
        p_lo_reg <= 36'(ds_reg) * 36'(recip[13:0]);
        p_hi_reg <= 36'(ds_reg) * 36'(recip[RECIP_W-1:14]);
        hz_reg   <= hm_w * zoom36;
    end

    // stage three: quotient by depth ratio, truncating divide by four
    assign prod   = {p_hi_reg, 14'd0} + 50'(p_lo_reg);
    assign hz_adj = hz_reg + $signed(36'({hz_reg[35], hz_reg[35]}));

    always_ff @(posedge aclk) begin
        q_reg <= prod[RECIP_SHIFT+21:RECIP_SHIFT];
        t_reg <= 34'(hz_adj >>> 2);
    end

    // stage four: offsets and saturation
    assign ys_sum = 38'($signed(cfg.cam_y)) + $signed({16'd0, q_reg}) - 38'(t_reg);
    assign xs_sum = 24'(dx_reg) + 24'($signed(cfg.cam_x));

    always_comb begin
        p_next.x = 32'(xs_sum);
        if (ys_sum[37:31] == '0 || ys_sum[37:31] == '1) begin
            p_next.y = ys_sum[31:0];
        end else if (ys_sum[37]) begin
            p_next.y = 32'h8000_0000;
        end else begin
            p_next.y = 32'h7fff_ffff;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            p_reg <= p_next;
        end
    end

    // neighbor registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            ul_reg   <= '0;
        end else if (cmd.commit) begin
            left_reg <= p_reg;
            ul_reg   <= up_reg;
        end
    end

    // row store write
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            row_mem[addr] <= p_reg;
        end
    end

    // output word selection
    assign is_tri = (cfg.draw_mode == MODE_TRI_BOTH) || (cfg.draw_mode == MODE_TRI_UPPER);

    always_comb begin
        case (cmd.slot)
            SLOT_LEFT: b_sel = left_reg;
            SLOT_UP:   b_sel = up_reg;
            default:   b_sel = ul_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.last <= cmd.last;
            out_reg.kind <= is_tri ? KIND_TRI : KIND_SEG;
            out_reg.a    <= is_tri ? ul_reg : p_reg;
            out_reg.b    <= b_sel;
            out_reg.c    <= is_tri ? p_reg : '0;
        end
    end

    assign out_word = out_reg;

endmodule

// ===== src/iweg_ctrl.sv =====
// sequencing state machine: capture, four arithmetic steps, primitive emission
`timescale 1ns / 1ps
module iweg_ctrl
    import iweg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] draw_mode,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_SUM,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] mask_reg, mask_next;
    logic       valid_reg, valid_next;
    logic [2:0] pick;
    logic       both_nz;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign both_nz  = status.col_nz && status.row_nz;

    // lowest pending slot
    always_comb begin
        if (mask_reg[0]) begin
            pick = 3'b001;
        end else if (mask_reg[1]) begin
            pick = 3'b010;
        end else begin
            pick = 3'b100;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        mask_next  = mask_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        cmd.slot   = pick[0] ? SLOT_LEFT : (pick[1] ? SLOT_UP : SLOT_DIAG);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                // a sample outside the grid is dropped here
                state_next = status.in_grid ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_SUM;
            ST_SUM: begin
                cmd.load_point = 1'b1;
                case (draw_mode)
                    MODE_GRID, MODE_DIAG: begin
                        mask_next = {draw_mode == MODE_DIAG && both_nz,
                                     status.row_nz, status.col_nz};
                    end
                    default: begin
                        mask_next = {1'b0, both_nz,
                                     draw_mode == MODE_TRI_BOTH && both_nz};
                    end
                endcase
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (mask_reg == '0) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else if (!valid_reg || m_tready) begin
                    mask_next    = mask_reg & ~pick;
                    cmd.load_out = 1'b1;
                    cmd.last     = (mask_next == '0);
                    valid_next   = 1'b1;
                    if (mask_next == '0) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== src/isometric_wireframe_edge_gen_unit.sv =====
// top level of the isometric wireframe edge generator
// after an input word is taken, the multiply, scale, divide and sum states run, then emit
// the emit state registers one primitive word at a time, holding while m_tready is low;
//   a new sample is taken only in idle, once every primitive of the last one is out
// samples outside the grid are dropped after the multiply state and produce nothing
// reset: synchronous, active low; clears control and neighbor points, sets config defaults
`timescale 1ns / 1ps
module isometric_wireframe_edge_gen_unit
    import iweg_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input word: col[9:0], row[19:10], height[35:20], zero pad [39:36]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,
    // output word: ax, ay, bx, by_coord, cx, cy, 32 bits each from bit 0
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    // kind[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    out_word_t  out_word;

    // configuration registers
    iweg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    iweg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .draw_mode (cfg.draw_mode),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and storage
    iweg_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_col    (s_tdata[9:0]),
        .s_row    (s_tdata[19:10]),
        .s_height (s_tdata[35:20]),
        .cmd      (cmd),
        .status   (status),
        .out_word (out_word)
    );

    // output packing
    assign m_tdata = {out_word.c, out_word.b, out_word.a};
    assign m_tuser = out_word.kind;
    assign m_tlast = out_word.last;

    // a taken sample keeps the input side closed for the next cycle
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("input side open right after a sample was taken");

    // segments carry a zero third vertex
    a_seg_zero_c: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_SEG) |-> m_tdata[191:128] == '0
    ) else $error("segment word with nonzero third vertex");

    // no primitive appears in the cycle after a sample is taken
    a_no_early_word: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid
    ) else $error("output word appeared before the projection finished");

endmodule
